### rtl/npcs_pkg.sv
// ----------------------------------------------------------------------------
// npcs_pkg
// Shared types and constants of the nearest palette color search block.
// ----------------------------------------------------------------------------
`default_nettype none

package npcs_pkg;

    localparam int PALETTE_ENTRIES = 256;
    localparam int IDX_W           = $clog2(PALETTE_ENTRIES);
    localparam int COUNT_W         = 9;
    localparam int DEPTH_W         = 4;
    localparam int CHAN_W          = 8;
    localparam int COLOR_W         = 3 * CHAN_W;
    localparam int SQ_W            = 2 * CHAN_W;
    localparam int DIST_W          = 18;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = COUNT_W;

    localparam logic [DIST_W-1:0]  NO_MATCH_DISTANCE = DIST_W'(256 * 256 * 3);
    localparam logic [DEPTH_W-1:0] FULL_DEPTH        = DEPTH_W'(8);
    localparam logic [DEPTH_W-1:0] MIN_DEPTH         = DEPTH_W'(1);
    localparam logic [COUNT_W-1:0] COUNT_MAX         = COUNT_W'(PALETTE_ENTRIES);

    // request operations
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_DEPTH   = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rgb_t;

    // travels with a palette read through the distance stages
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] index;
    } tag_t;

endpackage

`default_nettype wire

### rtl/npcs_req_if.sv
// ----------------------------------------------------------------------------
// npcs_req_if
// Request channel: palette loads and nearest color queries.
// ----------------------------------------------------------------------------
`default_nettype none

interface npcs_req_if;
    logic                          valid;
    logic                          ready;
    logic                          operation;
    logic [npcs_pkg::IDX_W-1:0]    entry_index;
    logic [npcs_pkg::CHAN_W-1:0]   red;
    logic [npcs_pkg::CHAN_W-1:0]   green;
    logic [npcs_pkg::CHAN_W-1:0]   blue;

    modport source (output valid, operation, entry_index, red, green, blue, input ready);
    modport sink   (input valid, operation, entry_index, red, green, blue, output ready);
endinterface

`default_nettype wire

### rtl/npcs_rsp_if.sv
// ----------------------------------------------------------------------------
// npcs_rsp_if
// Result channel: chosen palette index and its squared distance.
// ----------------------------------------------------------------------------
`default_nettype none

interface npcs_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [npcs_pkg::IDX_W-1:0]    nearest_index;
    logic [npcs_pkg::DIST_W-1:0]   nearest_distance;

    modport source (output valid, nearest_index, nearest_distance, input ready);
    modport sink   (input valid, nearest_index, nearest_distance, output ready);
endinterface

`default_nettype wire

### rtl/npcs_ram.sv
// ----------------------------------------------------------------------------
// npcs_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module npcs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/npcs_dist.sv
// ----------------------------------------------------------------------------
// npcs_dist
// Squared distance stage: per-channel squares registered, then summed.
// ----------------------------------------------------------------------------
`default_nettype none

module npcs_dist (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire npcs_pkg::tag_t                tag_in,
    input  wire npcs_pkg::rgb_t                query,
    input  wire npcs_pkg::rgb_t                entry,
    output      npcs_pkg::tag_t                tag_out,
    output      logic [npcs_pkg::DIST_W-1:0]   distance
);

    logic [npcs_pkg::CHAN_W-1:0] diff_r;
    logic [npcs_pkg::CHAN_W-1:0] diff_g;
    logic [npcs_pkg::CHAN_W-1:0] diff_b;
    logic [npcs_pkg::SQ_W-1:0]   sq_r_reg;
    logic [npcs_pkg::SQ_W-1:0]   sq_g_reg;
    logic [npcs_pkg::SQ_W-1:0]   sq_b_reg;
    npcs_pkg::tag_t              tag_reg;

    always_comb
    begin
        diff_r = (query.red   > entry.red)   ? query.red   - entry.red
                                             : entry.red   - query.red;
        diff_g = (query.green > entry.green) ? query.green - entry.green
                                             : entry.green - query.green;
        diff_b = (query.blue  > entry.blue)  ? query.blue  - entry.blue
                                             : entry.blue  - query.blue;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else
        begin
            tag_reg <= tag_in;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_r_reg <= npcs_pkg::SQ_W'(diff_r) * npcs_pkg::SQ_W'(diff_r);
        sq_g_reg <= npcs_pkg::SQ_W'(diff_g) * npcs_pkg::SQ_W'(diff_g);
        sq_b_reg <= npcs_pkg::SQ_W'(diff_b) * npcs_pkg::SQ_W'(diff_b);
    end

    assign tag_out  = tag_reg;
    assign distance = npcs_pkg::DIST_W'(sq_r_reg) + npcs_pkg::DIST_W'(sq_g_reg)
                    + npcs_pkg::DIST_W'(sq_b_reg);

endmodule

`default_nettype wire

### rtl/nearest_palette_color_search.sv
// ----------------------------------------------------------------------------
// nearest_palette_color_search
// Palette memory with a sequential nearest-entry search by squared distance.
// ----------------------------------------------------------------------------
// Load: one request per cycle while the block is idle, written to the palette RAM, no result.
// Query: the scan reads palette entries 0 to N-1, with N = palette_count clamped
//   to 256, one RAM entry per cycle (single read port); ready stays low from the
//   taken request until the result register is loaded, which also waits while
//   an earlier result is still held in the result register.
// Reset: palette_count 256, color_depth_bits 8; palette contents undefined.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_palette_color_search (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [npcs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [npcs_pkg::CFG_DATA_W-1:0]  cfg_data,
    npcs_req_if.sink                              req,
    npcs_rsp_if.source                            rsp
);

    npcs_pkg::state_t                 state_reg, state_next;
    logic [npcs_pkg::COUNT_W-1:0]     count_reg;
    logic [npcs_pkg::DEPTH_W-1:0]     depth_reg;
    logic [npcs_pkg::COUNT_W-1:0]     issue_reg, issue_next;
    logic [npcs_pkg::COUNT_W-1:0]     limit_reg, limit_next;
    npcs_pkg::rgb_t                   query_reg, query_next;
    npcs_pkg::tag_t                   tag1_reg, tag1_next;
    logic [npcs_pkg::DIST_W-1:0]      best_dist_reg, best_dist_next;
    logic [npcs_pkg::IDX_W-1:0]       best_idx_reg, best_idx_next;
    logic                             out_valid_reg, out_valid_next;
    logic [npcs_pkg::IDX_W-1:0]       out_idx_reg, out_idx_next;
    logic [npcs_pkg::DIST_W-1:0]      out_dist_reg, out_dist_next;

    logic                             req_fire;
    logic                             ram_we;
    logic                             ram_re;
    npcs_pkg::rgb_t                   ram_rdata;
    npcs_pkg::rgb_t                   load_color;
    npcs_pkg::tag_t                   tag2;
    logic [npcs_pkg::DIST_W-1:0]      dist2;
    logic [npcs_pkg::DEPTH_W-1:0]     depth_eff;
    logic [2:0]                       shift;

    assign req.ready = (state_reg == npcs_pkg::ST_IDLE);
    assign req_fire  = req.valid && req.ready;

    assign load_color.red   = req.red;
    assign load_color.green = req.green;
    assign load_color.blue  = req.blue;
    assign ram_we = req_fire && (req.operation == npcs_pkg::OP_LOAD);

    always_comb
    begin
        if (depth_reg < npcs_pkg::MIN_DEPTH)
        begin
            depth_eff = npcs_pkg::MIN_DEPTH;
        end
        else if (depth_reg > npcs_pkg::FULL_DEPTH)
        begin
            depth_eff = npcs_pkg::FULL_DEPTH;
        end
        else
        begin
            depth_eff = depth_reg;
        end
        shift = 3'(npcs_pkg::FULL_DEPTH - depth_eff);
    end

    npcs_ram #(
        .WIDTH (npcs_pkg::COLOR_W),
        .DEPTH (npcs_pkg::PALETTE_ENTRIES)
    ) u_palette (
        .clk   (clk),
        .we    (ram_we),
        .waddr (req.entry_index),
        .wdata (load_color),
        .re    (ram_re),
        .raddr (issue_reg[npcs_pkg::IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    npcs_dist u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .tag_in   (tag1_reg),
        .query    (query_reg),
        .entry    (ram_rdata),
        .tag_out  (tag2),
        .distance (dist2)
    );

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= npcs_pkg::COUNT_MAX;
            depth_reg <= npcs_pkg::FULL_DEPTH;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                npcs_pkg::CFG_PALETTE_COUNT: count_reg <= cfg_data;
                npcs_pkg::CFG_COLOR_DEPTH:   depth_reg <= cfg_data[npcs_pkg::DEPTH_W-1:0];
                default:                     ;
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        issue_next     = issue_reg;
        limit_next     = limit_reg;
        query_next     = query_reg;
        best_dist_next = best_dist_reg;
        best_idx_next  = best_idx_reg;
        out_valid_next = out_valid_reg;
        out_idx_next   = out_idx_reg;
        out_dist_next  = out_dist_reg;
        tag1_next      = '0;
        ram_re         = 1'b0;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        // fold the distance that leaves the square stage into the running best
        if (tag2.valid && (dist2 < best_dist_reg))
        begin
            best_dist_next = dist2;
            best_idx_next  = tag2.index;
        end

        case (state_reg)
            npcs_pkg::ST_IDLE:
            begin
                if (req_fire && (req.operation == npcs_pkg::OP_QUERY))
                begin
                    query_next.red   = 8'(req.red << shift);
                    query_next.green = 8'(req.green << shift);
                    query_next.blue  = 8'(req.blue << shift);
                    limit_next       = (count_reg > npcs_pkg::COUNT_MAX)
                                     ? npcs_pkg::COUNT_MAX : count_reg;
                    issue_next       = '0;
                    best_dist_next   = npcs_pkg::NO_MATCH_DISTANCE;
                    best_idx_next    = '0;
                    state_next       = npcs_pkg::ST_SCAN;
                end
            end
            npcs_pkg::ST_SCAN:
            begin
                if (issue_reg < limit_reg)
                begin
                    ram_re          = 1'b1;
                    tag1_next.valid = 1'b1;
                    tag1_next.index = issue_reg[npcs_pkg::IDX_W-1:0];
                    issue_next      = issue_reg + 1'b1;
                end
                else if (!tag1_reg.valid && !tag2.valid)
                begin
                    state_next = npcs_pkg::ST_RESULT;
                end
            end
            npcs_pkg::ST_RESULT:
            begin
                // hold until the result register is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_idx_next   = best_idx_reg;
                    out_dist_next  = best_dist_reg;
                    state_next     = npcs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = npcs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= npcs_pkg::ST_IDLE;
            issue_reg     <= '0;
            tag1_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_reg     <= issue_next;
            tag1_reg      <= tag1_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        limit_reg     <= limit_next;
        query_reg     <= query_next;
        best_dist_reg <= best_dist_next;
        best_idx_reg  <= best_idx_next;
        out_idx_reg   <= out_idx_next;
        out_dist_reg  <= out_dist_next;
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.nearest_index    = out_idx_reg;
    assign rsp.nearest_distance = out_dist_reg;

endmodule

`default_nettype wire

### rtl/npcs_checker.sv
// ----------------------------------------------------------------------------
// npcs_checker
// Port-level checks of the nearest palette color search block.
// ----------------------------------------------------------------------------
`default_nettype none

module npcs_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           req_valid,
    input wire logic                           req_ready,
    input wire logic                           req_operation,
    input wire logic                           rsp_valid,
    input wire logic                           rsp_ready,
    input wire logic [npcs_pkg::IDX_W-1:0]     rsp_index,
    input wire logic [npcs_pkg::DIST_W-1:0]    rsp_distance
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_index) && $stable(rsp_distance))
        else $error("result changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_distance <= npcs_pkg::NO_MATCH_DISTANCE)
        else $error("distance above empty-search value");

    // the empty-search distance only comes with index zero
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_distance == npcs_pkg::NO_MATCH_DISTANCE) |-> rsp_index == '0)
        else $error("empty search with nonzero index");

    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_operation == npcs_pkg::OP_QUERY) |=> !req_ready)
        else $error("request taken during a query scan");

    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_operation == npcs_pkg::OP_LOAD) |=> req_ready)
        else $error("load stalled the request channel");

endmodule

bind nearest_palette_color_search npcs_checker u_npcs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .req_operation (req.operation),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_index     (rsp.nearest_index),
    .rsp_distance  (rsp.nearest_distance)
);

`default_nettype wire
